@@ design/assert_macros.svh @@
// Shared assertion macros for the design folder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain clocked property, disabled while reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Antecedent in this cycle implies consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ design/pcps_pkg.sv @@
package pcps_pkg;

  // Search limits.
  localparam int MAX_OUT_DIV  = 127;
  localparam int MAX_MAIN_DIV = 9;
  localparam int MAX_FB_MULT  = 64;

  // Fixed field widths.
  localparam int REF_W  = 20;
  localparam int FREQ_W = 26;
  localparam int OUT_C_W = 7;
  localparam int OUT_M_W = 7;
  localparam int OUT_D_W = 4;

  // Internal counter widths follow from the limits.
  localparam int CW_I = $clog2(MAX_OUT_DIV + 1);
  localparam int MW_I = $clog2(MAX_FB_MULT + 1);
  localparam int DW_I = $clog2(MAX_MAIN_DIV + 1);

  // Dividend (reference times multiplier) and divisor (main times output divider).
  localparam int NUM_W = REF_W + MW_I;
  localparam int DEN_W = DW_I + CW_I;
  localparam int ERR_W = (NUM_W > FREQ_W) ? NUM_W : FREQ_W;
  localparam int CNT_W = $clog2(NUM_W);

  localparam logic [REF_W-1:0] REF_RESET = REF_W'(100000);

  typedef struct packed {
    logic            start;  // new search: capture target, mark the next evaluation as the first
    logic            load;   // form dividend and divisor for the current candidate
    logic            step;   // one restoring division step
    logic            eval;   // compare quotient against the best so far
    logic            emit;   // move the best setting into the output register
    logic [DW_I-1:0] d;
    logic [MW_I-1:0] m;
    logic [CW_I-1:0] c;
  } pcps_cmd_t;

  typedef struct packed {
    logic match;  // quotient equals the target exactly
  } pcps_status_t;

endpackage

@@ design/pcps_datapath.sv @@
`include "assert_macros.svh"

module pcps_datapath
  import pcps_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [REF_W-1:0]    cfg_data,
  input  logic [FREQ_W-1:0]   target_freq,
  input  pcps_cmd_t           cmd,
  output pcps_status_t        status,
  output logic [OUT_C_W-1:0]  clock_div,
  output logic [OUT_M_W-1:0]  feedback_mult,
  output logic [OUT_D_W-1:0]  main_div,
  output logic [FREQ_W-1:0]   achieved_freq
);

  logic [REF_W-1:0]  ref_r;
  logic [FREQ_W-1:0] target_r;
  logic [NUM_W-1:0]  quo_r;
  logic [DEN_W-1:0]  rem_r;
  logic [DEN_W-1:0]  den_r;
  logic              first_r;
  logic [ERR_W-1:0]  best_err_r;
  logic [CW_I-1:0]   best_c_r;
  logic [MW_I-1:0]   best_m_r;
  logic [DW_I-1:0]   best_d_r;
  logic [NUM_W-1:0]  best_f_r;

  logic [OUT_C_W-1:0] out_c_r;
  logic [OUT_M_W-1:0] out_m_r;
  logic [OUT_D_W-1:0] out_d_r;
  logic [FREQ_W-1:0]  out_f_r;

  logic [DEN_W:0]    trial;
  logic              trial_ge;
  logic [DEN_W:0]    trial_diff;
  logic [ERR_W-1:0]  f_ext;
  logic [ERR_W-1:0]  t_ext;
  logic [ERR_W-1:0]  err;
  logic              better;
  logic              saturate;

  // One restoring division step: shift in the next dividend bit, subtract if it fits.
  assign trial      = {rem_r, quo_r[NUM_W-1]};
  assign trial_ge   = trial >= {1'b0, den_r};
  assign trial_diff = trial - {1'b0, den_r};

  assign f_ext  = ERR_W'(quo_r);
  assign t_ext  = ERR_W'(target_r);
  assign err    = (f_ext > t_ext) ? (f_ext - t_ext) : (t_ext - f_ext);
  assign better = first_r || (err < best_err_r);

  assign status.match = (f_ext == t_ext);

  assign saturate = ERR_W'(best_f_r) > ERR_W'({FREQ_W{1'b1}});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_r <= REF_RESET;
    end else if (cfg_we) begin
      ref_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      target_r <= target_freq;
    end
    if (cmd.load) begin
      quo_r <= NUM_W'(ref_r * MW_I'(cmd.m));
      den_r <= DEN_W'(DEN_W'(cmd.d) * DEN_W'(cmd.c));
      rem_r <= '0;
    end else if (cmd.step) begin
      quo_r <= {quo_r[NUM_W-2:0], trial_ge};
      rem_r <= trial_ge ? trial_diff[DEN_W-1:0] : trial[DEN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      first_r <= 1'b1;
    end else if (cmd.eval) begin
      first_r <= 1'b0;
      if (better) begin
        best_err_r <= err;
        best_c_r   <= cmd.c;
        best_m_r   <= cmd.m;
        best_d_r   <= cmd.d;
        best_f_r   <= quo_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_c_r <= OUT_C_W'(best_c_r);
      out_m_r <= OUT_M_W'(best_m_r);
      out_d_r <= OUT_D_W'(best_d_r);
      out_f_r <= saturate ? {FREQ_W{1'b1}} : FREQ_W'(best_f_r);
    end
  end

  assign clock_div     = out_c_r;
  assign feedback_mult = out_m_r;
  assign main_div      = out_d_r;
  assign achieved_freq = out_f_r;

  // The divisor is never zero while a division is running.
  `ASSERT_CLK(a_den_nonzero, clk, rst_n, cmd.step |-> (den_r != '0), "divisor is zero during a division step")
  // The remainder stays below the divisor after every step.
  `ASSERT_NEXT(a_rem_below_den, clk, rst_n, cmd.step, rem_r < den_r, "remainder not below divisor")

endmodule

@@ design/pcps_ctrl.sv @@
`include "assert_macros.svh"

module pcps_ctrl
  import pcps_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_stall,
  output logic         out_valid,
  input  logic         out_stall,
  input  pcps_status_t status,
  output pcps_cmd_t    cmd
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_LOAD = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_EVAL = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  localparam int LIM_W = DW_I + MW_I + 4;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NUM_W - 1);

  logic [2:0]       state_r, state_nxt;
  logic [DW_I-1:0]  d_r, d_nxt;
  logic [MW_I-1:0]  m_r, m_nxt;
  logic [CW_I-1:0]  c_r, c_nxt;
  logic [CNT_W-1:0] bit_cnt_r, bit_cnt_nxt;
  logic             out_valid_r, out_valid_nxt;

  logic             accept;
  logic             c_last;
  logic             m_last;
  logic             d_last;
  logic [DW_I-1:0]  d_inc;
  logic [LIM_W-1:0] m_ext;
  logic [LIM_W-1:0] m_hi;
  logic [LIM_W-1:0] next_lo;
  logic             can_emit;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign can_emit = !out_valid_r || !out_stall;

  // Multiplier range for the current main divider is 6*d up to min(12*d, cap).
  assign d_inc   = d_r + DW_I'(1);
  assign m_ext   = LIM_W'(m_r);
  assign m_hi    = LIM_W'(d_r) * LIM_W'(12);
  assign next_lo = LIM_W'(d_inc) * LIM_W'(6);
  assign c_last  = (c_r == CW_I'(MAX_OUT_DIV));
  assign m_last  = (m_ext >= m_hi) || (m_ext >= LIM_W'(MAX_FB_MULT));
  assign d_last  = (d_r == DW_I'(MAX_MAIN_DIV)) || (next_lo > LIM_W'(MAX_FB_MULT));

  always_comb begin
    state_nxt     = state_r;
    d_nxt         = d_r;
    m_nxt         = m_r;
    c_nxt         = c_r;
    bit_cnt_nxt   = bit_cnt_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    cmd.d         = d_r;
    cmd.m         = m_r;
    cmd.c         = c_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cmd.start = 1'b1;
          d_nxt     = DW_I'(1);
          m_nxt     = MW_I'(6);
          c_nxt     = CW_I'(1);
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        cmd.load    = 1'b1;
        bit_cnt_nxt = '0;
        state_nxt   = ST_DIV;
      end
      ST_DIV: begin
        cmd.step    = 1'b1;
        bit_cnt_nxt = bit_cnt_r + CNT_W'(1);
        if (bit_cnt_r == CNT_LAST) begin
          state_nxt = ST_EVAL;
        end
      end
      ST_EVAL: begin
        cmd.eval = 1'b1;
        if (status.match || (c_last && m_last && d_last)) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_LOAD;
          if (!c_last) begin
            c_nxt = c_r + CW_I'(1);
          end else begin
            c_nxt = CW_I'(1);
            if (!m_last) begin
              m_nxt = m_r + MW_I'(1);
            end else begin
              d_nxt = d_inc;
              m_nxt = MW_I'(next_lo);
            end
          end
        end
      end
      ST_DONE: begin
        if (can_emit) begin
          cmd.emit      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      d_r         <= '0;
      m_r         <= '0;
      c_r         <= '0;
      bit_cnt_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      d_r         <= d_nxt;
      m_r         <= m_nxt;
      c_r         <= c_nxt;
      bit_cnt_r   <= bit_cnt_nxt;
    end
  end

  assign out_valid = out_valid_r;

  `ASSERT_NEXT(a_accept_loads, clk, rst_n, accept, state_r == ST_LOAD, "accepted word did not start a search")
  `ASSERT_NEXT(a_div_to_eval, clk, rst_n, state_r == ST_DIV && bit_cnt_r == CNT_LAST, state_r == ST_EVAL, "division did not end in evaluation")
  `ASSERT_CLK(a_idx_range, clk, rst_n, (state_r != ST_IDLE) |-> (d_r != '0 && d_r <= DW_I'(MAX_MAIN_DIV) && m_r <= MW_I'(MAX_FB_MULT) && c_r != '0), "search index out of range")
  `ASSERT_NEXT(a_emit_shows, clk, rst_n, cmd.emit, out_valid_r && state_r == ST_IDLE, "emitted result not presented")

endmodule

@@ design/pll_clock_parameter_search_unit.sv @@
// Each candidate setting passes through load, divide and compare: LOAD forms reference*M and
// D*C, DIV runs the shared one-bit-per-cycle restoring divider over all NUM_W quotient bits,
// and EVAL compares. A full search visits 22225 candidates; an exact match ends the search
// early. One word at a time.
// Reset (rst_n, synchronous, active low) empties the block and sets the reference to 100000.
// A new word is accepted while the previous result still waits on the output register.

module pll_clock_parameter_search_unit
  import pcps_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  // Input channel: target frequency.
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [FREQ_W-1:0]   in_target_freq,
  // Result channel: chosen settings and the frequency they produce.
  output logic                out_valid,
  input  logic                out_stall,
  output logic [OUT_C_W-1:0]  out_clock_div,
  output logic [OUT_M_W-1:0]  out_feedback_mult,
  output logic [OUT_D_W-1:0]  out_main_div,
  output logic [FREQ_W-1:0]   out_achieved_freq,
  // Configuration channel: reference frequency.
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [REF_W-1:0]    cfg_data
);

  pcps_cmd_t    cmd;
  pcps_status_t status;

  // The reference register takes a write whenever one is offered; the user must make writes
  // only while the block is idle, and the block itself does not enforce this.
  assign cfg_ready = 1'b1;

  // The controller walks the main divider, then the multiplier, then the output
  // divider innermost, and sequences the datapath through load, divide and compare.
  pcps_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // The datapath holds the reference, the divider, the running best setting and the
  // output register.
  pcps_datapath u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_valid && cfg_ready),
    .cfg_data      (cfg_data),
    .target_freq   (in_target_freq),
    .cmd           (cmd),
    .status        (status),
    .clock_div     (out_clock_div),
    .feedback_mult (out_feedback_mult),
    .main_div      (out_main_div),
    .achieved_freq (out_achieved_freq)
  );

endmodule
